/* rtl/core/bjdt_pkg.sv */
// Shared types, constants and helpers for the batched job dispatch table.
// Used by bjdt_ctrl, bjdt_dp and batched_job_dispatch_table_unit.
`timescale 1ns / 1ps
`default_nettype none
package bjdt_pkg;

	localparam int MAX_JOBS    = 64;
	localparam int MAX_BATCHES = 64;
	localparam int JIW         = $clog2(MAX_JOBS);
	localparam int BIW         = $clog2(MAX_BATCHES);
	localparam int CNT_W       = 7;

	localparam logic [1:0] FUNC_ADD    = 2'd0;
	localparam logic [1:0] FUNC_NEXT   = 2'd1;
	localparam logic [1:0] FUNC_CLEAR  = 2'd2;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOPEND   = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef struct packed {
		logic [1:0]  func;
		logic [63:0] job_entry;
		logic [63:0] job_arg;
		logic        last_of_batch;
		logic [31:0] job_id;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [31:0]      issued_id;
		logic [63:0]      issued_entry;
		logic [63:0]      issued_arg;
		logic [31:0]      done_batch;
		logic             has_work;
		logic [CNT_W-1:0] jobs_num;
		logic [CNT_W-1:0] batches_num;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic take;
		logic find;
		logic pick;
		logic bfind;
		logic bapply;
		logic load;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] func;
		logic       jfound;
		logic       out_free;
	} stat_t;

	function automatic logic [31:0] bump_id(input logic [31:0] c);
		logic [31:0] n;
		n = c + 32'd1;
		return (n == 32'd0) ? 32'd1 : n;
	endfunction

	function automatic logic [JIW-1:0] first_job(input logic [MAX_JOBS-1:0] v);
		logic [JIW-1:0] r;
		r = '0;
		for (int k = MAX_JOBS - 1; k >= 0; k--) begin
			if (v[k]) r = JIW'(k);
		end
		return r;
	endfunction

	function automatic logic [BIW-1:0] first_bat(input logic [MAX_BATCHES-1:0] v);
		logic [BIW-1:0] r;
		r = '0;
		for (int k = MAX_BATCHES - 1; k >= 0; k--) begin
			if (v[k]) r = BIW'(k);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/batched_job_dispatch_table_unit.sv */
// Top level of the batched job dispatch table: controller plus datapath.
// Depends on bjdt_pkg, bjdt_ctrl and bjdt_dp.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+----------------------
//  in      | to unit   | in_valid / in_stall   | in_item  (in_item_t)
//  out     | from unit | out_valid / out_stall | out_item (out_item_t)
//
// One item at a time. After acceptance an add goes from the search state
// to the result load; take-next and a clear of an unknown id pass search
// and select; a clear that hits passes search, select, batch search and
// apply. The steps follow the registered match vectors over the 64 job
// cells, and the result load waits while the output register is held.
// The result sits in an output register, so the next item is accepted
// while it waits; a stalled result holds the last state until taken.
// Reset clears counts and id counters; the tables need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module batched_job_dispatch_table_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire bjdt_pkg::in_item_t in_item,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output bjdt_pkg::out_item_t     out_item
);

	bjdt_pkg::cmd_t  cmd;
	bjdt_pkg::stat_t st;

	// sequencer: accept, search, select, batch update, result load
	bjdt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	// tables, counters and result register
	bjdt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cmd       (cmd),
		.st        (st),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule
`default_nettype wire

/* rtl/core/bjdt_ctrl.sv */
// Sequencing state machine for the job dispatch table.
// Depends on bjdt_pkg; drives bjdt_dp through cmd_t, reads stat_t.
`timescale 1ns / 1ps
`default_nettype none
module bjdt_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire bjdt_pkg::stat_t st,
	output bjdt_pkg::cmd_t       cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_FIND   = 3'd1;
	localparam logic [2:0] S_PICK   = 3'd2;
	localparam logic [2:0] S_BFIND  = 3'd3;
	localparam logic [2:0] S_BAPPLY = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	logic [2:0] state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.take = in_valid;
				if (in_valid) state_d = S_FIND;
			end
			S_FIND: begin
				cmd.find = 1'b1;
				if (st.func == bjdt_pkg::FUNC_NEXT || st.func == bjdt_pkg::FUNC_CLEAR)
					state_d = S_PICK;
				else
					state_d = S_DONE;
			end
			S_PICK: begin
				cmd.pick = 1'b1;
				if (st.func == bjdt_pkg::FUNC_CLEAR && st.jfound) state_d = S_BFIND;
				else state_d = S_DONE;
			end
			S_BFIND: begin
				cmd.bfind = 1'b1;
				state_d   = S_BAPPLY;
			end
			S_BAPPLY: begin
				cmd.bapply = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				cmd.load = st.out_free;
				if (st.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	assign in_stall = (state_q != S_IDLE);

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.take, cmd.find, cmd.pick, cmd.bfind, cmd.bapply, cmd.load}))
		else $error("more than one command at once");
	a_take_then_find: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |=> state_q == S_FIND)
		else $error("accepted item not searched");
	a_bfind_then_apply: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.bfind |=> cmd.bapply)
		else $error("batch search not applied");

endmodule
`default_nettype wire

/* rtl/core/bjdt_dp.sv */
// Datapath: compacting job and batch cell rows, payload memory, id counters,
// result and output registers. Depends on bjdt_pkg; commanded by bjdt_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module bjdt_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire bjdt_pkg::in_item_t in_item,
	input  wire bjdt_pkg::cmd_t     cmd,
	output bjdt_pkg::stat_t         st,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output bjdt_pkg::out_item_t     out_item
);

	localparam int NJ = bjdt_pkg::MAX_JOBS;
	localparam int NB = bjdt_pkg::MAX_BATCHES;
	localparam int JW = bjdt_pkg::JIW;
	localparam int BW = bjdt_pkg::BIW;
	localparam int CW = bjdt_pkg::CNT_W;

	bjdt_pkg::in_item_t item_q;

	// job cells, kept in insertion order
	logic [31:0]   cell_id   [NJ];
	logic [31:0]   cell_bat  [NJ];
	logic          cell_busy [NJ];
	logic [JW-1:0] cell_ptr  [NJ];
	// batch cells
	logic [31:0]   bat_id    [NB];
	logic [CW-1:0] bat_cnt   [NB];
	// entry/arg store, addressed by physical slot
	logic [127:0]  pay_mem   [NJ];
	logic [127:0]  rd_q;

	logic [CW-1:0] jobs_q, bats_q;
	logic [31:0]   next_job_q, next_bat_q, open_bid_q;
	logic          inprog_q;
	logic [NJ-1:0] free_q;
	logic          out_valid_q;

	logic [NJ-1:0] jmatch_s1;
	logic [NB-1:0] bmatch_s1;
	logic [31:0]   owner_q;

	logic [1:0]  res_status_q;
	logic [31:0] res_iid_q, res_bid_q;
	logic        res_issued_q;

	// add
	logic          opening, full, add_ok;
	logic [31:0]   new_bid;
	logic [JW-1:0] alloc, jtail;
	logic [BW-1:0] btail, blast;
	logic [CW-1:0] bats_m1;
	// pick
	logic [JW-1:0] jidx;
	logic          jfound;
	logic          is_next, is_clear;
	// batch apply
	logic [BW-1:0] bidx;
	logic          bfound, bopen, bremove;
	logic [CW-1:0] bdec;

	assign opening = !inprog_q;
	assign full    = (jobs_q == CW'(NJ)) || (opening && bats_q == CW'(NB));
	assign add_ok  = cmd.find && item_q.func == bjdt_pkg::FUNC_ADD && !full;
	assign new_bid = opening ? bjdt_pkg::bump_id(next_bat_q) : open_bid_q;
	assign alloc   = bjdt_pkg::first_job(free_q);
	assign jtail   = jobs_q[JW-1:0];
	assign btail   = bats_q[BW-1:0];
	assign bats_m1 = bats_q - CW'(1);
	assign blast   = bats_m1[BW-1:0];

	assign is_next  = item_q.func == bjdt_pkg::FUNC_NEXT;
	assign is_clear = item_q.func == bjdt_pkg::FUNC_CLEAR;
	assign jidx     = bjdt_pkg::first_job(jmatch_s1);
	assign jfound   = |jmatch_s1;

	assign bidx    = bjdt_pkg::first_bat(bmatch_s1);
	assign bfound  = |bmatch_s1;
	assign bdec    = (bat_cnt[bidx] != '0) ? bat_cnt[bidx] - CW'(1) : '0;
	assign bopen   = inprog_q && bidx == blast;
	assign bremove = bfound && bdec == '0 && !bopen;

	assign st.func     = item_q.func;
	assign st.jfound   = jfound;
	assign st.out_free = !out_valid_q || !out_stall;

	// item, match vectors, results
	always_ff @(posedge clk) begin
		if (cmd.take) item_q <= in_item;
		if (cmd.find) begin
			for (int k = 0; k < NJ; k++) begin
				jmatch_s1[k] <= (CW'(k) < jobs_q) &&
					(is_next ? !cell_busy[k] :
					 (is_clear && item_q.job_id != 32'd0 && cell_id[k] == item_q.job_id));
			end
			res_status_q <= (item_q.func == bjdt_pkg::FUNC_ADD && full) ?
				bjdt_pkg::ST_FULL : bjdt_pkg::ST_OK;
			res_iid_q    <= '0;
			res_bid_q    <= (add_ok && item_q.last_of_batch) ? new_bid : 32'd0;
			res_issued_q <= 1'b0;
		end
		if (cmd.pick) begin
			if (is_next) begin
				if (jfound) begin
					res_iid_q    <= cell_id[jidx];
					res_issued_q <= 1'b1;
				end else begin
					res_status_q <= bjdt_pkg::ST_NOPEND;
				end
			end else begin
				if (!jfound) res_status_q <= bjdt_pkg::ST_NOTFOUND;
				owner_q <= cell_bat[jidx];
			end
		end
		if (cmd.bfind) begin
			for (int k = 0; k < NB; k++)
				bmatch_s1[k] <= (CW'(k) < bats_q) && bat_id[k] == owner_q;
		end
		if (cmd.bapply && bremove) res_bid_q <= owner_q;
	end

	// payload store
	always_ff @(posedge clk) begin
		if (add_ok) pay_mem[alloc] <= {item_q.job_entry, item_q.job_arg};
	end
	always_ff @(posedge clk) begin
		if (cmd.pick) rd_q <= pay_mem[cell_ptr[jidx]];
	end

	// job cells: append at tail, mark busy, compact on removal
	always_ff @(posedge clk) begin
		for (int k = 0; k < NJ; k++) begin
			if (add_ok && JW'(k) == jtail) begin
				cell_id[k]   <= bjdt_pkg::bump_id(next_job_q);
				cell_bat[k]  <= new_bid;
				cell_busy[k] <= 1'b0;
				cell_ptr[k]  <= alloc;
			end else if (cmd.pick && is_next && jfound && JW'(k) == jidx) begin
				cell_busy[k] <= 1'b1;
			end else if (cmd.pick && is_clear && jfound && JW'(k) >= jidx && k < NJ - 1) begin
				cell_id[k]   <= cell_id[(k + 1) % NJ];
				cell_bat[k]  <= cell_bat[(k + 1) % NJ];
				cell_busy[k] <= cell_busy[(k + 1) % NJ];
				cell_ptr[k]  <= cell_ptr[(k + 1) % NJ];
			end
		end
	end

	// batch cells
	always_ff @(posedge clk) begin
		for (int k = 0; k < NB; k++) begin
			if (add_ok && opening && BW'(k) == btail) begin
				bat_id[k]  <= new_bid;
				bat_cnt[k] <= CW'(1);
			end else if (add_ok && !opening && BW'(k) == blast) begin
				bat_cnt[k] <= bat_cnt[k] + CW'(1);
			end else if (cmd.bapply && bfound && !bremove && BW'(k) == bidx) begin
				bat_cnt[k] <= bdec;
			end else if (cmd.bapply && bremove && BW'(k) >= bidx && k < NB - 1) begin
				bat_id[k]  <= bat_id[(k + 1) % NB];
				bat_cnt[k] <= bat_cnt[(k + 1) % NB];
			end
		end
	end

	// counters and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jobs_q      <= '0;
			bats_q      <= '0;
			next_job_q  <= '0;
			next_bat_q  <= '0;
			open_bid_q  <= '0;
			inprog_q    <= 1'b0;
			free_q      <= '1;
			out_valid_q <= 1'b0;
		end else begin
			if (add_ok) begin
				jobs_q        <= jobs_q + CW'(1);
				next_job_q    <= bjdt_pkg::bump_id(next_job_q);
				free_q[alloc] <= 1'b0;
				if (opening) begin
					bats_q     <= bats_q + CW'(1);
					next_bat_q <= new_bid;
					open_bid_q <= new_bid;
				end
				inprog_q <= !item_q.last_of_batch;
			end
			if (cmd.pick && is_clear && jfound) begin
				jobs_q                 <= jobs_q - CW'(1);
				free_q[cell_ptr[jidx]] <= 1'b1;
			end
			if (cmd.bapply && bremove) bats_q <= bats_q - CW'(1);
			if (cmd.load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_item.status       <= res_status_q;
			out_item.issued_id    <= res_iid_q;
			out_item.issued_entry <= res_issued_q ? rd_q[127:64] : 64'd0;
			out_item.issued_arg   <= res_issued_q ? rd_q[63:0] : 64'd0;
			out_item.done_batch   <= res_bid_q;
			out_item.has_work     <= (jobs_q != '0) || (bats_q != '0);
			out_item.jobs_num     <= jobs_q;
			out_item.batches_num  <= bats_q;
		end
	end

	assign out_valid = out_valid_q;

	a_free_tally: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(free_q) + int'(jobs_q) == NJ)
		else $error("free slots and held jobs disagree");
	a_counts_bound: assert property (@(posedge clk) disable iff (!arst_n)
		jobs_q <= CW'(NJ) && bats_q <= CW'(NB))
		else $error("count beyond table size");
	a_open_has_record: assert property (@(posedge clk) disable iff (!arst_n)
		inprog_q |-> bats_q != '0)
		else $error("open batch without a record");

endmodule
`default_nettype wire
